FILE: src/stwl_pkg.sv
// Shared types, codes and helper functions of the socket table with wildcard lookup.
// Used by the controller, the datapath and the top level.
package stwl_pkg;

    localparam int NUM_ENTRIES_DEF = 256;

    localparam logic [7:0]  IPV4_MASK_RST = 8'h01;
    localparam logic [15:0] WILD_PORT_RST = 16'h0000;
    localparam logic [31:0] WILD_IPV4_RST = 32'h0000_0000;

    typedef enum logic [1:0] {
        ACT_CREATE = 2'd0,
        ACT_BIND   = 2'd1,
        ACT_LOOKUP = 2'd2
    } action_t;

    typedef enum logic [1:0] {
        STAT_OK      = 2'd0,
        STAT_FULL    = 2'd1,
        STAT_NOMATCH = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        CFG_IPV4_MASK = 2'd0,
        CFG_WILD_PORT = 2'd1,
        CFG_WILD_IPV4 = 2'd2
    } cfg_index_t;

    typedef enum logic [1:0] {
        RK_HIT     = 2'd0,
        RK_FULL    = 2'd1,
        RK_NOMATCH = 2'd2,
        RK_BIND    = 2'd3
    } res_kind_t;

    typedef enum logic [2:0] {
        ST_CLEAR  = 3'd0,
        ST_IDLE   = 3'd1,
        ST_CREATE = 3'd2,
        ST_LOOKUP = 3'd3,
        ST_BIND   = 3'd4,
        ST_RESP   = 3'd5
    } ctrl_state_t;

    typedef struct packed {
        logic [7:0]  protocol;
        logic [15:0] port;
        logic [31:0] ipv4;
    } addr_t;

    typedef struct packed {
        addr_t loc_addr;
        addr_t rem_addr;
    } entry_t;

    typedef struct packed {
        logic      in_ready;
        logic      load;
        logic      scan;
        logic      clear;
        logic      create_wr;
        logic      bind_wr;
        logic      res_load;
        res_kind_t res_kind;
        logic      out_push;
    } cmd_t;

    typedef struct packed {
        logic       in_valid;
        logic [1:0] in_action;
        logic       free_hit;
        logic       match_hit;
        logic       exhausted;
        logic       clear_done;
        logic       out_free;
    } sts_t;

    function automatic logic addr_match(
        input addr_t       a,
        input addr_t       b,
        input logic [7:0]  mask,
        input logic [15:0] wport,
        input logic [31:0] wip
    );
        logic port_ok;
        logic proto_ok;
        logic ip_ok;
        port_ok  = (a.port == wport) || (b.port == wport) || (a.port == b.port);
        proto_ok = ((a.protocol & mask) != 8'h00) && ((b.protocol & mask) != 8'h00);
        ip_ok    = (a.ipv4 == wip) || (b.ipv4 == wip) || (a.ipv4 == b.ipv4);
        return port_ok && proto_ok && ip_ok;
    endfunction

endpackage

FILE: src/stwl_if.sv
// Handshake interfaces of the socket table: request, response and register write channels.
// Does not import stwl_pkg; its widths match the field types there.
interface stwl_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  action;
    logic [7:0]  socket_id;
    logic [7:0]  local_protocol;
    logic [15:0] local_port;
    logic [31:0] local_ipv4;
    logic [7:0]  remote_protocol;
    logic [15:0] remote_port;
    logic [31:0] remote_ipv4;

    modport source (
        output valid, action, socket_id, local_protocol, local_port, local_ipv4,
        output remote_protocol, remote_port, remote_ipv4,
        input  ready
    );
    modport sink (
        input  valid, action, socket_id, local_protocol, local_port, local_ipv4,
        input  remote_protocol, remote_port, remote_ipv4,
        output ready
    );
endinterface

interface stwl_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] status;
    logic [7:0] result_id;

    modport source (output valid, status, result_id, input ready);
    modport sink (input valid, status, result_id, output ready);
endinterface

interface stwl_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [31:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

FILE: src/stwl_ctrl.sv
// Controller state machine of the socket table: clearing pass, scans, bind and response.
// Depends on stwl_pkg for the state, command and status types.
module stwl_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  stwl_pkg::sts_t  sts,
    output stwl_pkg::cmd_t  cmd
);

    stwl_pkg::ctrl_state_t state_reg;
    stwl_pkg::ctrl_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= stwl_pkg::ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.res_kind = stwl_pkg::RK_NOMATCH;
        case (state_reg)
            stwl_pkg::ST_CLEAR:
            begin
                cmd.clear = 1'b1;
                if (sts.clear_done)
                begin
                    state_next = stwl_pkg::ST_IDLE;
                end
            end
            stwl_pkg::ST_IDLE:
            begin
                cmd.in_ready = 1'b1;
                if (sts.in_valid)
                begin
                    cmd.load = 1'b1;
                    case (sts.in_action)
                        stwl_pkg::ACT_CREATE: state_next = stwl_pkg::ST_CREATE;
                        stwl_pkg::ACT_BIND:   state_next = stwl_pkg::ST_BIND;
                        stwl_pkg::ACT_LOOKUP: state_next = stwl_pkg::ST_LOOKUP;
                        default:
                        begin
                            cmd.res_load = 1'b1;
                            cmd.res_kind = stwl_pkg::RK_NOMATCH;
                            state_next   = stwl_pkg::ST_RESP;
                        end
                    endcase
                end
            end
            stwl_pkg::ST_CREATE:
            begin
                if (sts.free_hit)
                begin
                    cmd.create_wr = 1'b1;
                    cmd.res_load  = 1'b1;
                    cmd.res_kind  = stwl_pkg::RK_HIT;
                    state_next    = stwl_pkg::ST_RESP;
                end
                else if (sts.exhausted)
                begin
                    cmd.res_load = 1'b1;
                    cmd.res_kind = stwl_pkg::RK_FULL;
                    state_next   = stwl_pkg::ST_RESP;
                end
                else
                begin
                    cmd.scan = 1'b1;
                end
            end
            stwl_pkg::ST_LOOKUP:
            begin
                if (sts.match_hit)
                begin
                    cmd.res_load = 1'b1;
                    cmd.res_kind = stwl_pkg::RK_HIT;
                    state_next   = stwl_pkg::ST_RESP;
                end
                else if (sts.exhausted)
                begin
                    cmd.res_load = 1'b1;
                    cmd.res_kind = stwl_pkg::RK_NOMATCH;
                    state_next   = stwl_pkg::ST_RESP;
                end
                else
                begin
                    cmd.scan = 1'b1;
                end
            end
            stwl_pkg::ST_BIND:
            begin
                cmd.bind_wr  = 1'b1;
                cmd.res_load = 1'b1;
                cmd.res_kind = stwl_pkg::RK_BIND;
                state_next   = stwl_pkg::ST_RESP;
            end
            stwl_pkg::ST_RESP:
            begin
                if (sts.out_free)
                begin
                    cmd.out_push = 1'b1;
                    state_next   = stwl_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = stwl_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

FILE: src/stwl_datapath.sv
// Datapath of the socket table: entry memories, scan counter, match logic, registers, result.
// Depends on stwl_pkg and on the channel interfaces in stwl_if.
module stwl_datapath #(
    parameter int NUM_ENTRIES = stwl_pkg::NUM_ENTRIES_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    stwl_in_if.sink         req,
    stwl_out_if.source      rsp,
    stwl_cfg_if.sink        cfg,
    input  stwl_pkg::cmd_t  cmd,
    output stwl_pkg::sts_t  sts
);

    localparam int IDX_W = (NUM_ENTRIES > 2) ? $clog2(NUM_ENTRIES) : 1;
    localparam int CNT_W = $clog2(NUM_ENTRIES + 1);
    localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(NUM_ENTRIES - 1);
    localparam logic [CNT_W-1:0] END_CNT  = CNT_W'(NUM_ENTRIES);

    logic [7:0]  mask_reg;
    logic [15:0] wport_reg;
    logic [31:0] wip_reg;

    logic [7:0]      socket_id_reg;
    stwl_pkg::addr_t loc_reg;
    stwl_pkg::addr_t rem_reg;

    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    logic             rd_valid_reg;
    logic             rd_valid_next;
    logic [IDX_W-1:0] rd_idx_reg;

    logic               used_mem [NUM_ENTRIES];
    stwl_pkg::entry_t   entry_mem [NUM_ENTRIES];
    logic               used_rd_reg;
    stwl_pkg::entry_t   entry_rd_reg;

    logic               used_we;
    logic [IDX_W-1:0]   used_wa;
    logic               entry_we;
    logic [IDX_W-1:0]   entry_wa;
    stwl_pkg::entry_t   entry_wd;
    logic               bind_ok;
    logic               free_hit;
    logic               match_hit;

    stwl_pkg::status_t  res_status_reg;
    logic [7:0]         res_id_reg;
    logic               out_valid_reg;
    stwl_pkg::status_t  out_status_reg;
    logic [7:0]         out_id_reg;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_reg  <= stwl_pkg::IPV4_MASK_RST;
            wport_reg <= stwl_pkg::WILD_PORT_RST;
            wip_reg   <= stwl_pkg::WILD_IPV4_RST;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                stwl_pkg::CFG_IPV4_MASK: mask_reg  <= cfg.data[7:0];
                stwl_pkg::CFG_WILD_PORT: wport_reg <= cfg.data[15:0];
                stwl_pkg::CFG_WILD_IPV4: wip_reg   <= cfg.data;
                default:
                begin
                end
            endcase
        end
    end

    assign req.ready = cmd.in_ready;

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            socket_id_reg    <= req.socket_id;
            loc_reg.protocol <= req.local_protocol;
            loc_reg.port     <= req.local_port;
            loc_reg.ipv4     <= req.local_ipv4;
            rem_reg.protocol <= req.remote_protocol;
            rem_reg.port     <= req.remote_port;
            rem_reg.ipv4     <= req.remote_ipv4;
        end
    end

    always_comb
    begin
        cnt_next      = cnt_reg;
        rd_valid_next = 1'b0;
        if (cmd.load)
        begin
            cnt_next = (req.action == stwl_pkg::ACT_CREATE) ? CNT_W'(1) : '0;
        end
        else if (cmd.clear)
        begin
            cnt_next = cnt_reg + CNT_W'(1);
        end
        else if (cmd.scan && (cnt_reg != END_CNT))
        begin
            cnt_next      = cnt_reg + CNT_W'(1);
            rd_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg      <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            cnt_reg      <= cnt_next;
            rd_valid_reg <= rd_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_valid_next)
        begin
            rd_idx_reg <= cnt_reg[IDX_W-1:0];
        end
    end

    assign bind_ok  = int'(socket_id_reg) < NUM_ENTRIES;
    assign used_we  = cmd.clear | cmd.create_wr;
    assign used_wa  = cmd.clear ? cnt_reg[IDX_W-1:0] : rd_idx_reg;
    assign entry_we = cmd.create_wr | (cmd.bind_wr & bind_ok);
    assign entry_wa = cmd.create_wr ? rd_idx_reg : IDX_W'(socket_id_reg);

    always_comb
    begin
        entry_wd = '0;
        if (!cmd.create_wr)
        begin
            entry_wd.loc_addr          = loc_reg;
            entry_wd.rem_addr.protocol = loc_reg.protocol;
            entry_wd.rem_addr.port     = wport_reg;
            entry_wd.rem_addr.ipv4     = wip_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (used_we)
        begin
            used_mem[used_wa] <= cmd.create_wr;
        end
        if (rd_valid_next)
        begin
            used_rd_reg <= used_mem[cnt_reg[IDX_W-1:0]];
        end
    end

    always_ff @(posedge clk)
    begin
        if (entry_we)
        begin
            entry_mem[entry_wa] <= entry_wd;
        end
        if (rd_valid_next)
        begin
            entry_rd_reg <= entry_mem[cnt_reg[IDX_W-1:0]];
        end
    end

    assign free_hit  = rd_valid_reg & ~used_rd_reg;
    assign match_hit = rd_valid_reg & used_rd_reg
        & stwl_pkg::addr_match(rem_reg, entry_rd_reg.rem_addr, mask_reg, wport_reg, wip_reg)
        & stwl_pkg::addr_match(loc_reg, entry_rd_reg.loc_addr, mask_reg, wport_reg, wip_reg);

    always_ff @(posedge clk)
    begin
        if (cmd.res_load)
        begin
            case (cmd.res_kind)
                stwl_pkg::RK_HIT:
                begin
                    res_status_reg <= stwl_pkg::STAT_OK;
                    res_id_reg     <= 8'(rd_idx_reg);
                end
                stwl_pkg::RK_FULL:
                begin
                    res_status_reg <= stwl_pkg::STAT_FULL;
                    res_id_reg     <= 8'd0;
                end
                stwl_pkg::RK_BIND:
                begin
                    res_status_reg <= bind_ok ? stwl_pkg::STAT_OK : stwl_pkg::STAT_NOMATCH;
                    res_id_reg     <= bind_ok ? socket_id_reg : 8'd0;
                end
                default:
                begin
                    res_status_reg <= stwl_pkg::STAT_NOMATCH;
                    res_id_reg     <= 8'd0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_push)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_push)
        begin
            out_status_reg <= res_status_reg;
            out_id_reg     <= res_id_reg;
        end
    end

    assign rsp.valid     = out_valid_reg;
    assign rsp.status    = out_status_reg;
    assign rsp.result_id = out_id_reg;

    assign sts.in_valid   = req.valid;
    assign sts.in_action  = req.action;
    assign sts.free_hit   = free_hit;
    assign sts.match_hit  = match_hit;
    assign sts.exhausted  = (cnt_reg == END_CNT) && !rd_valid_reg;
    assign sts.clear_done = (cnt_reg == LAST_CNT);
    assign sts.out_free   = !out_valid_reg || rsp.ready;

    // A create only ever claims an entry that the scan has just read as free.
    a_create_on_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.create_wr |-> free_hit)
        else $error("create wrote an entry that was not read as free");

    // Read data is only marked valid in the cycle after the controller asked for a scan step.
    a_read_follows_scan: assert property (@(posedge clk) disable iff (!rst_n)
        rd_valid_reg |-> $past(cmd.scan))
        else $error("scan read data valid without a scan step");

    // Every failure word carries entry index zero.
    a_fail_id_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (out_status_reg != stwl_pkg::STAT_OK)) |-> (out_id_reg == 8'd0))
        else $error("failure word with a nonzero entry index");

endmodule

FILE: src/socket_table_wildcard_lookup_top.sv
// Top level of the socket table with wildcard lookup: controller plus datapath.
// Depends on stwl_pkg, stwl_if, stwl_ctrl and stwl_datapath.
//
// After reset the block clears the used marks of all NUM_ENTRIES entries and takes no
// request words in that time; register writes are accepted at any time. The block then
// handles one request at a time. A bind writes its entry in the bind state when the
// socket id is in range, and its response word is pushed from the response state. A create
// reads the used marks from entry 1 upward, one entry per cycle from a single memory read
// port, and answers with the first free entry, or with a full status when the table is
// full. A lookup reads one entry per cycle from entry 0 and answers on the first match,
// or with no match when nothing matches. A new request is accepted while the previous
// response word still waits to be taken.
module socket_table_wildcard_lookup_top #(
    parameter int NUM_ENTRIES = stwl_pkg::NUM_ENTRIES_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    stwl_in_if.sink     req,
    stwl_out_if.source  rsp,
    stwl_cfg_if.sink    cfg
);

    stwl_pkg::cmd_t cmd;
    stwl_pkg::sts_t sts;

    stwl_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .sts   (sts),
        .cmd   (cmd)
    );

    stwl_datapath #(
        .NUM_ENTRIES (NUM_ENTRIES)
    ) u_datapath (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp),
        .cfg   (cfg),
        .cmd   (cmd),
        .sts   (sts)
    );

endmodule
